// File: hw/rtl/dsd_pkg.sv
// Shared types, constants and fixed-point helpers for the dielectric scatter pipeline.
`default_nettype none
package dsd_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int WIDE_W   = 32;
  localparam int INDEX_W  = 14;
  localparam int RF_W     = 16;
  localparam int UV_W     = 14;
  localparam int QUO_W    = 13;
  localparam int RND_W    = 53;
  localparam int RAD_SH_W = 44;
  localparam logic [INDEX_W-1:0] INDEX_RESET = 14'd6144;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [UV_W-1:0]   uv_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  typedef struct packed {
    wide_t idx_nz;
    wide_t idx2;
    wide_t eta_enter;
    wide_t e2_enter;
    wide_t r0;
    wide_t omr0;
  } idx_consts_t;

  function automatic wide_t sat_wide(input logic signed [65:0] v);
    wide_t res;
    if (v > 66'sh7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -66'sh8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic rnd_t rnd12(input logic signed [63:0] p);
    logic signed [64:0] s;
    s = 65'(p) + 65'sd2048;
    return s[64:12];
  endfunction

  function automatic wide_t qmul(input wide_t a, input wide_t b);
    logic signed [63:0] p;
    p = a * b;
    return sat_wide(66'(rnd12(p)));
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dielectric_scatter_direction_core.sv
// Top level: dielectric scatter direction pipeline with Snell refraction and Schlick reflectance.
// Accepts one ray per cycle while in_stall is low; the pipeline depth is set by the 32-stage
// length root, the 13-stage per-lane dividers for the unit direction and the 22-stage roots for
// the refraction and leaving cosines. A stalled result freezes the whole pipeline. After reset
// and after every index write the block derives the index constants (reciprocal index and
// Schlick base term), holding in_stall and lowering cfg_ready meanwhile.
`default_nettype none
module dielectric_scatter_direction_core import dsd_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dir_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dir_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dir_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_normal_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_normal_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_normal_z,
  input  logic        [RF_W-1:0]            in_random_fraction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z,
  output logic                              out_took_reflection,
  output logic                              out_total_internal,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [INDEX_W-1:0]         cfg_refraction_index
);
  localparam int ST_IN   = 1;
  localparam int ST_SUM  = 3;
  localparam int ST_LEN  = ST_SUM + WIDE_W;
  localparam int ST_NUM  = ST_LEN + 1;
  localparam int ST_Q    = ST_NUM + QUO_W;
  localparam int ST_UV   = ST_Q + 1;
  localparam int ST_C    = ST_UV + 2;
  localparam int ST_SEL  = ST_C + 1;
  localparam int ST_RAD  = ST_SEL + 3;
  localparam int ST_ROOT = ST_RAD + RAD_SH_W / 2;
  localparam int ST_X    = ST_ROOT + 1;
  localparam int ST_PROB = ST_X + 6;
  localparam int ST_OUT  = ST_PROB + 1;
  localparam int NUM_W   = WIDE_W + QUO_W;

  localparam logic signed [WIDE_W:0] OUT_HI =
    (WIDE_W+1)'((65'sd1 <<< (COMPONENT_WIDTH - 1)) - 65'sd1);
  localparam logic signed [WIDE_W:0] OUT_LO = -OUT_HI - 33'sd1;

  function automatic logic signed [COMPONENT_WIDTH-1:0] sat_out(input wide_t v);
    logic signed [WIDE_W:0] res;
    if (33'(v) > OUT_HI) begin
      res = OUT_HI;
    end else if (33'(v) < OUT_LO) begin
      res = OUT_LO;
    end else begin
      res = 33'(v);
    end
    return res[COMPONENT_WIDTH-1:0];
  endfunction

  idx_consts_t cst;
  logic        cfg_busy;
  logic        adv;
  logic        accept;

  logic vld_r [ST_IN:ST_OUT];

  wide_t           d_line_r   [ST_IN:ST_LEN][3];
  wide_t           n_line_r   [ST_IN:ST_C][3];
  logic [RF_W-1:0] rf_line_r  [ST_IN:ST_PROB];
  rnd_t            pdn_r      [3];
  logic [63:0]     pdd_r      [3];
  wide_t           dn_r;
  logic [63:0]     sumsq_r;
  logic            lv_line_r  [ST_SUM:ST_ROOT];
  wide_t           qdn_r      [3];
  wide_t           r_line_r   [ST_SUM+2:ST_PROB][3];
  logic [WIDE_W-1:0] len;
  logic [NUM_W-1:0]  num_r    [3];
  logic [WIDE_W-1:0] den_r;
  logic            sgn_line_r [ST_NUM:ST_Q][3];
  logic            lz_line_r  [ST_NUM:ST_Q];
  logic [QUO_W-1:0] quo       [3];
  uv_t             uv_line_r  [ST_UV:ST_SEL+1][3];
  rnd_t            cp_r       [3];
  wide_t           c_r;
  wide_t           negc;
  wide_t           cc_r;
  wide_t           dt_r;
  wide_t           negc_line_r [ST_SEL:ST_ROOT];
  wide_t           eta_line_r  [ST_SEL:ST_SEL+2];
  wide_t           m_line_r    [ST_SEL:ST_ROOT][3];
  wide_t           omc_r;
  wide_t           qmd_r       [3];
  wide_t           qa_r;
  wide_t           qb_r;
  wide_t           tang_r      [3];
  wide_t           rad;
  wide_t           disc;
  logic [RAD_SH_W-1:0] rad_sh_r;
  logic [RAD_SH_W-1:0] disc_sh_r;
  logic            tir_line_r  [ST_RAD:ST_PROB];
  wide_t           qet_line_r  [ST_RAD:ST_X][3];
  logic [RAD_SH_W/2-1:0] cos_root;
  logic [RAD_SH_W/2-1:0] sq_root;
  wide_t           cos_sel;
  wide_t           x_line_r    [ST_X:ST_X+3];
  wide_t           qms_r       [3];
  wide_t           t_line_r    [ST_X+1:ST_PROB][3];
  wide_t           p2_r;
  wide_t           p3_r;
  wide_t           p4_r;
  wide_t           p5_r;
  wide_t           qp_r;
  wide_t           prob_r;
  logic            took;

  dsd_cfg u_cfg (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_refraction_index (cfg_refraction_index),
    .busy                 (cfg_busy),
    .consts               (cst)
  );

  assign adv      = !(vld_r[ST_OUT] && out_stall);
  assign in_stall = !adv || cfg_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = ST_IN; k <= ST_OUT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[ST_IN] <= accept;
      for (int k = ST_IN + 1; k <= ST_OUT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ray length and reflection
  always_ff @(posedge clk) begin
    if (adv) begin
      d_line_r[ST_IN][0] <= WIDE_W'(in_dir_x);
      d_line_r[ST_IN][1] <= WIDE_W'(in_dir_y);
      d_line_r[ST_IN][2] <= WIDE_W'(in_dir_z);
      n_line_r[ST_IN][0] <= WIDE_W'(in_normal_x);
      n_line_r[ST_IN][1] <= WIDE_W'(in_normal_y);
      n_line_r[ST_IN][2] <= WIDE_W'(in_normal_z);
      rf_line_r[ST_IN]   <= in_random_fraction;
      for (int k = ST_IN + 1; k <= ST_LEN; k++) d_line_r[k] <= d_line_r[k-1];
      for (int k = ST_IN + 1; k <= ST_C; k++) n_line_r[k] <= n_line_r[k-1];
      for (int k = ST_IN + 1; k <= ST_PROB; k++) rf_line_r[k] <= rf_line_r[k-1];
      for (int i = 0; i < 3; i++) begin
        pdn_r[i] <= rnd12(d_line_r[ST_IN][i] * n_line_r[ST_IN][i]);
        pdd_r[i] <= d_line_r[ST_IN][i] * d_line_r[ST_IN][i];
      end
      dn_r    <= sat_wide(66'(pdn_r[0]) + 66'(pdn_r[1]) + 66'(pdn_r[2]));
      lv_line_r[ST_SUM] <= (66'(pdn_r[0]) + 66'(pdn_r[1]) + 66'(pdn_r[2])) > 66'sd0;
      for (int k = ST_SUM + 1; k <= ST_ROOT; k++) lv_line_r[k] <= lv_line_r[k-1];
      sumsq_r <= pdd_r[0] + pdd_r[1] + pdd_r[2];
      for (int i = 0; i < 3; i++) begin
        qdn_r[i] <= qmul(dn_r, n_line_r[ST_SUM][i]);
        r_line_r[ST_SUM+2][i] <= sat_wide(66'(d_line_r[ST_SUM+1][i]) - (66'(qdn_r[i]) <<< 1));
      end
      for (int k = ST_SUM + 3; k <= ST_PROB; k++) r_line_r[k] <= r_line_r[k-1];
    end
  end

  dsd_isqrt #(.IW(2 * WIDE_W)) u_len_root (
    .clk  (clk),
    .en   (adv),
    .val  (sumsq_r),
    .root (len)
  );

  // unit direction
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NUM_W'({(d_line_r[ST_LEN][i][WIDE_W-1]
                    ? WIDE_W'(-(WIDE_W+1)'(d_line_r[ST_LEN][i]))
                    : WIDE_W'(d_line_r[ST_LEN][i])), 12'b0}) + NUM_W'(len >> 1);
        sgn_line_r[ST_NUM][i] <= d_line_r[ST_LEN][i][WIDE_W-1];
      end
      den_r <= len;
      lz_line_r[ST_NUM] <= (len == '0);
      for (int k = ST_NUM + 1; k <= ST_Q; k++) begin
        sgn_line_r[k] <= sgn_line_r[k-1];
        lz_line_r[k]  <= lz_line_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    dsd_qdiv #(.DW(WIDE_W), .QW(QUO_W)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num_r[i]),
      .den (den_r),
      .quo (quo[i])
    );
  end

  assign negc = sat_wide(-66'(c_r));

  // cosine, discriminant and tangent part
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (lz_line_r[ST_Q]) begin
          uv_line_r[ST_UV][i] <= '0;
        end else if (sgn_line_r[ST_Q][i]) begin
          uv_line_r[ST_UV][i] <= uv_t'(-{1'b0, quo[i]});
        end else begin
          uv_line_r[ST_UV][i] <= uv_t'({1'b0, quo[i]});
        end
        cp_r[i] <= rnd12(WIDE_W'(uv_line_r[ST_UV][i]) * n_line_r[ST_UV][i]);
      end
      for (int k = ST_UV + 1; k <= ST_SEL + 1; k++) uv_line_r[k] <= uv_line_r[k-1];
      c_r  <= sat_wide(66'(cp_r[0]) + 66'(cp_r[1]) + 66'(cp_r[2]));
      cc_r <= qmul(c_r, c_r);
      dt_r <= lv_line_r[ST_C] ? negc : c_r;
      negc_line_r[ST_SEL] <= negc;
      eta_line_r[ST_SEL]  <= lv_line_r[ST_C] ? cst.idx_nz : cst.eta_enter;
      for (int i = 0; i < 3; i++) begin
        m_line_r[ST_SEL][i] <= lv_line_r[ST_C] ? sat_wide(-66'(n_line_r[ST_C][i]))
                                               : n_line_r[ST_C][i];
      end
      for (int k = ST_SEL + 1; k <= ST_ROOT; k++) begin
        negc_line_r[k] <= negc_line_r[k-1];
        m_line_r[k]    <= m_line_r[k-1];
      end
      for (int k = ST_SEL + 1; k <= ST_SEL + 2; k++) eta_line_r[k] <= eta_line_r[k-1];
      omc_r <= sat_wide(66'sd4096 - 66'(cc_r));
      for (int i = 0; i < 3; i++) begin
        qmd_r[i]  <= qmul(m_line_r[ST_SEL][i], dt_r);
        tang_r[i] <= sat_wide(66'(uv_line_r[ST_SEL+1][i]) - 66'(qmd_r[i]));
        qet_line_r[ST_RAD][i] <= qmul(eta_line_r[ST_SEL+2], tang_r[i]);
      end
      for (int k = ST_RAD + 1; k <= ST_X; k++) qet_line_r[k] <= qet_line_r[k-1];
      qa_r <= qmul(cst.idx2, omc_r);
      qb_r <= qmul(lv_line_r[ST_SEL+1] ? cst.idx2 : cst.e2_enter, omc_r);
      rad_sh_r  <= (rad > 0) ? {1'b0, rad[WIDE_W-2:0], 12'b0} : '0;
      disc_sh_r <= (disc > 0) ? {1'b0, disc[WIDE_W-2:0], 12'b0} : '0;
      tir_line_r[ST_RAD] <= !(disc > 0);
      for (int k = ST_RAD + 1; k <= ST_PROB; k++) tir_line_r[k] <= tir_line_r[k-1];
    end
  end

  assign rad  = sat_wide(66'sd4096 - 66'(qa_r));
  assign disc = sat_wide(66'sd4096 - 66'(qb_r));

  dsd_isqrt #(.IW(RAD_SH_W)) u_cos_root (
    .clk  (clk),
    .en   (adv),
    .val  (rad_sh_r),
    .root (cos_root)
  );

  dsd_isqrt #(.IW(RAD_SH_W)) u_disc_root (
    .clk  (clk),
    .en   (adv),
    .val  (disc_sh_r),
    .root (sq_root)
  );

  assign cos_sel = lv_line_r[ST_ROOT] ? $signed(WIDE_W'(cos_root)) : negc_line_r[ST_ROOT];
  assign took    = tir_line_r[ST_PROB] ||
                   ($signed({21'b0, rf_line_r[ST_PROB]}) < (37'(prob_r) <<< 4));

  // refraction vector, Schlick probability and output select
  always_ff @(posedge clk) begin
    if (adv) begin
      x_line_r[ST_X] <= sat_wide(66'sd4096 - 66'(cos_sel));
      for (int k = ST_X + 1; k <= ST_X + 3; k++) x_line_r[k] <= x_line_r[k-1];
      for (int i = 0; i < 3; i++) begin
        qms_r[i] <= qmul(m_line_r[ST_ROOT][i], $signed(WIDE_W'(sq_root)));
        t_line_r[ST_X+1][i] <= sat_wide(66'(qet_line_r[ST_X][i]) - 66'(qms_r[i]));
      end
      for (int k = ST_X + 2; k <= ST_PROB; k++) t_line_r[k] <= t_line_r[k-1];
      p2_r   <= qmul(x_line_r[ST_X], x_line_r[ST_X]);
      p3_r   <= qmul(p2_r, x_line_r[ST_X+1]);
      p4_r   <= qmul(p3_r, x_line_r[ST_X+2]);
      p5_r   <= qmul(p4_r, x_line_r[ST_X+3]);
      qp_r   <= qmul(cst.omr0, p5_r);
      prob_r <= sat_wide(66'(cst.r0) + 66'(qp_r));
      out_x  <= sat_out(took ? r_line_r[ST_PROB][0] : t_line_r[ST_PROB][0]);
      out_y  <= sat_out(took ? r_line_r[ST_PROB][1] : t_line_r[ST_PROB][1]);
      out_z  <= sat_out(took ? r_line_r[ST_PROB][2] : t_line_r[ST_PROB][2]);
      out_took_reflection <= took;
      out_total_internal  <= tir_line_r[ST_PROB];
    end
  end

  assign out_valid = vld_r[ST_OUT];

  a_tir_reflects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_total_internal || out_took_reflection))
    else $error("total internal reflection without reflected direction");

  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_OUT] && out_stall) |=> ($stable(vld_r[ST_OUT-1]) && $stable(vld_r[ST_IN])))
    else $error("pipeline moved while output transfer stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_busy |=> !vld_r[ST_IN] || $stable(vld_r[ST_IN]))
    else $error("ray taken while index constants were being derived");

endmodule
`default_nettype wire

// File: hw/rtl/dsd_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none
module dsd_isqrt import dsd_pkg::*; #(
  parameter int IW = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IW-1:0]     val,
  output logic [IW/2-1:0]   root
);
  localparam int STEPS = IW / 2;

  logic [IW-1:0] rem_r [STEPS];
  logic [IW-1:0] res_r [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam logic [IW-1:0] BIT = {{(IW-1){1'b0}}, 1'b1} << (IW - 2 - 2 * s);
    logic [IW-1:0] rem_in;
    logic [IW-1:0] res_in;
    logic [IW:0]   trial;
    if (s == 0) begin : g_first
      assign rem_in = val;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign res_in = res_r[s-1];
    end
    assign trial = {1'b0, res_in} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[s] <= rem_in - trial[IW-1:0];
          res_r[s] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[s] <= rem_in;
          res_r[s] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[STEPS-1][IW/2-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/dsd_qdiv.sv
// Pipelined restoring divider with a short quotient, one quotient bit per stage.
`default_nettype none
module dsd_qdiv import dsd_pkg::*; #(
  parameter int DW = 32,
  parameter int QW = QUO_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);
  localparam int CW = DW + QW;

  logic [CW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [CW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] trial;
    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end
    assign trial = CW'(den_in) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          quo_r[s] <= quo_in | (QW'(1) << B);
        end else begin
          rem_r[s] <= rem_in;
          quo_r[s] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[QW-1];
endmodule
`default_nettype wire

// File: hw/rtl/dsd_cfg.sv
// Index register and sequencer that derives the per-index constants.
`default_nettype none
module dsd_cfg import dsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_refraction_index,
  output logic               busy,
  output idx_consts_t        consts
);
  localparam int DVD_W     = 26;
  localparam int DVS_W     = 15;
  localparam int DIV_STEPS = DVD_W;

  typedef enum logic [2:0] {
    S_LOAD_ETA, S_ETA, S_LOAD_R0, S_R0, S_SQ, S_FIN, S_IDLE
  } state_t;

  state_t             state_r;
  logic [INDEX_W-1:0] idx_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W-1:0]   rem_r;
  logic [4:0]         cnt_r;
  logic [DVD_W-1:0]   eta_q_r;
  logic [DVD_W-1:0]   r0q_r;
  idx_consts_t        consts_r;

  logic [INDEX_W-1:0] idx_nz;
  logic [INDEX_W-1:0] mag;
  logic [DVS_W-1:0]   den;
  logic [DVD_W-1:0]   eta_dvd;
  logic [DVD_W-1:0]   r0_dvd;
  logic [DVS_W:0]     rem_sh;
  logic               ge;
  logic [DVS_W-1:0]   rem_nxt;
  logic [DVD_W-1:0]   dvd_nxt;
  logic               last;

  always_comb begin
    idx_nz  = (idx_r == '0) ? INDEX_W'(1) : idx_r;
    mag     = (idx_r > 14'd4096) ? idx_r - 14'd4096 : 14'd4096 - idx_r;
    den     = 15'd4096 + DVS_W'(idx_r);
    eta_dvd = (DVD_W'(1) << 24) + DVD_W'(idx_nz >> 1);
    r0_dvd  = {mag, 12'b0} + DVD_W'(den >> 1);
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
    last    = (cnt_r == 5'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD_ETA;
      idx_r   <= INDEX_RESET;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_LOAD_ETA: begin
          dvd_r   <= eta_dvd;
          dvs_r   <= DVS_W'(idx_nz);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_ETA;
        end
        S_ETA: begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (last) begin
            eta_q_r <= dvd_nxt;
            state_r <= S_LOAD_R0;
          end
        end
        S_LOAD_R0: begin
          dvd_r   <= r0_dvd;
          dvs_r   <= den;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_R0;
        end
        S_R0: begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (last) begin
            r0q_r   <= dvd_nxt;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          consts_r.idx_nz    <= $signed(WIDE_W'(idx_nz));
          consts_r.idx2      <= qmul($signed(WIDE_W'(idx_nz)), $signed(WIDE_W'(idx_nz)));
          consts_r.eta_enter <= $signed(WIDE_W'(eta_q_r));
          consts_r.e2_enter  <= qmul($signed(WIDE_W'(eta_q_r)), $signed(WIDE_W'(eta_q_r)));
          consts_r.r0        <= qmul($signed(WIDE_W'(r0q_r)), $signed(WIDE_W'(r0q_r)));
          state_r            <= S_FIN;
        end
        S_FIN: begin
          consts_r.omr0 <= sat_wide(66'sd4096 - 66'(consts_r.r0));
          state_r       <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            idx_r   <= cfg_refraction_index;
            state_r <= S_LOAD_ETA;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready = (state_r == S_IDLE);
  assign busy      = !cfg_ready;
  assign consts    = consts_r;
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for dielectric_scatter_direction_core: bit-exact prediction, directed and random rays.
`default_nettype none
module tb;
  import dsd_pkg::*;

  localparam int CW = 16;
  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic took;
    logic tir;
  } scatter_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [CW-1:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [RF_W-1:0] in_random_fraction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic out_took_reflection, out_total_internal;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [INDEX_W-1:0] cfg_refraction_index = '0;

  longint glass_index;
  scatter_t expected_dirs[$];
  int mismatches = 0;
  int idle_pct = 26;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  dielectric_scatter_direction_core #(.COMPONENT_WIDTH(CW)) DUT (.*);

  always #5 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q12(longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat32(round_q12(a * b));
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint fx_dot(longint a[3], longint b[3]);
    return sat32(round_q12(a[0] * b[0]) + round_q12(a[1] * b[1]) + round_q12(a[2] * b[2]));
  endfunction

  function automatic longint schlick(longint cosine, longint idx);
    longint num, den, mag, r0q, r0, x, p;
    num = 4096 - idx;
    den = 4096 + idx;
    mag = num < 0 ? -num : num;
    r0q = (mag * 4096 + den / 2) / den;
    r0 = fx_mul(r0q, r0q);
    x = sat32(4096 - cosine);
    p = x;
    for (int k = 0; k < 4; k++) p = fx_mul(p, x);
    return sat32(r0 + fx_mul(sat32(4096 - r0), p));
  endfunction

  function automatic logic signed [CW-1:0] clip_out(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[CW-1:0];
  endfunction

  function automatic scatter_t scatter_ray(logic signed [CW-1:0] dx, dy, dz, nx, ny, nz,
                                           logic [15:0] rf);
    longint d[3], n[3], m[3], r[3], uv[3], t[3];
    longint idx, idx_nz, dn, c, dt, eta, cosine, e2, disc, prob, rad, sq, tang, q, mg;
    longint unsigned sumsq, len;
    logic tir, took;
    scatter_t res;
    d[0] = dx; d[1] = dy; d[2] = dz;
    n[0] = nx; n[1] = ny; n[2] = nz;
    idx = glass_index;
    idx_nz = idx != 0 ? idx : 1;
    dn = fx_dot(d, n);
    for (int i = 0; i < 3; i++) r[i] = sat32(d[i] - 2 * fx_mul(dn, n[i]));
    sumsq = 0;
    for (int i = 0; i < 3; i++) sumsq += longint'(d[i] * d[i]);
    len = int_root(sumsq);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        uv[i] = 0;
      end else begin
        mg = d[i] < 0 ? -d[i] : d[i];
        q = (mg * 4096 + longint'(len / 2)) / longint'(len);
        uv[i] = d[i] < 0 ? -q : q;
      end
    end
    c = fx_dot(uv, n);
    if (dn > 0) begin
      for (int i = 0; i < 3; i++) m[i] = -n[i];
      eta = idx_nz;
      dt = -c;
      rad = sat32(4096 - fx_mul(fx_mul(idx, idx), sat32(4096 - fx_mul(c, c))));
      cosine = rad > 0 ? int_root(rad << 12) : 0;
    end else begin
      for (int i = 0; i < 3; i++) m[i] = n[i];
      eta = (16777216 + idx_nz / 2) / idx_nz;
      dt = c;
      cosine = sat32(-c);
    end
    e2 = fx_mul(eta, eta);
    disc = sat32(4096 - fx_mul(e2, sat32(4096 - fx_mul(dt, dt))));
    tir = !(disc > 0);
    if (!tir) begin
      sq = int_root(disc << 12);
      for (int i = 0; i < 3; i++) begin
        tang = sat32(uv[i] - fx_mul(m[i], dt));
        t[i] = sat32(fx_mul(eta, tang) - fx_mul(m[i], sq));
      end
      prob = schlick(cosine, idx);
      took = longint'(rf) < prob * 16;
    end else begin
      for (int i = 0; i < 3; i++) t[i] = 0;
      took = 1'b1;
    end
    res.x = clip_out(took ? r[0] : t[0]);
    res.y = clip_out(took ? r[1] : t[1]);
    res.z = clip_out(took ? r[2] : t[2]);
    res.took = took;
    res.tir = tir;
    return res;
  endfunction

  task automatic send_ray(logic signed [CW-1:0] dx, dy, dz, nx, ny, nz, logic [15:0] rf);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_random_fraction <= rf;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_dirs.push_back(scatter_ray(dx, dy, dz, nx, ny, nz, rf));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_dirs.size() != 0) @(negedge clk);
  endtask

  task automatic write_index(logic [INDEX_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_refraction_index <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    glass_index = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_comp();
    return $urandom_range(3) == 0 ? CW'($urandom) : CW'($signed($urandom_range(8192)) - 4096);
  endfunction

  task automatic send_random_ray();
    logic signed [CW-1:0] nx, ny, nz;
    int axis;
    axis = $urandom_range(3);
    nx = 0; ny = 0; nz = 0;
    case (axis)
      0: nx = $urandom_range(1) ? 16'sd4096 : -16'sd4096;
      1: ny = $urandom_range(1) ? 16'sd4096 : -16'sd4096;
      2: nz = $urandom_range(1) ? 16'sd4096 : -16'sd4096;
      default: begin
        nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
      end
    endcase
    send_ray(rand_comp(), rand_comp(), rand_comp(), nx, ny, nz, 16'($urandom));
  endtask

  task automatic test_directed();
    send_ray(16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'd0);
    send_ray(16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'hFFFF);
    send_ray(16'sd2896, 16'sd0, -16'sd2896, 16'sd0, 16'sd0, 16'sd4096, 16'hFFFF);
    send_ray(16'sd3900, 16'sd0, 16'sd1200, 16'sd0, 16'sd0, 16'sd4096, 16'hFFFF);
    send_ray(16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'hFFFF);
    send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'h8000);
    send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h1234);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    send_ray(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd0);
    send_ray(16'shFFFF, 16'sh5555, 16'shAAAA, 16'sd0, -16'sd4096, 16'sd0, 16'h5555);
    send_ray(16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hAAAA);
    send_ray(-16'sd100, 16'sd50, -16'sd4000, 16'sd0, 16'sd0, -16'sd4096, 16'h0FFF);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_random_ray();
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_cycles = 300;
    for (int i = 0; i < 150; i++) send_random_ray();
    drain_results();
    test_random(10);
  endtask

  initial begin
    glass_index = 6144;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(500);
    write_index(14'd4096);
    test_directed();
    test_random(120);
    write_index(14'h3FFF);
    test_directed();
    test_random(120);
    write_index(14'd0);
    test_directed();
    test_random(60);
    write_index(14'd5461);
    idle_pct = 0;
    test_random(200);
    idle_pct = 26;
    test_backpressure();
    write_index(14'($urandom_range(4096, 16383)));
    test_random(340);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS dielectric_scatter_direction_core");
    end else begin
      $display("FAIL dielectric_scatter_direction_core");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    scatter_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_x, out_y, out_z, out_took_reflection, out_total_internal};
      if (expected_dirs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = expected_dirs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL dielectric_scatter_direction_core");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
